// File: src/vrcs_pkg.sv
// ----------------------------------------------------------------------------
// vrcs_pkg
// Shared widths and types for the voxel ray cell step pipeline.
// ----------------------------------------------------------------------------
package vrcs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 32;
   localparam int HEAD_W    = 18;
   // distance to the next side is at most 2^(2*FRAC_BITS); one quotient bit per stage
   localparam int QUO_W     = 2 * FRAC_BITS + 1;
   localparam int TRAVEL_W  = 33;
   localparam int SIDE_W    = POS_W + 2;
   localparam int PROD_W    = HEAD_W + QUO_W + 1;
   localparam int SUM_W     = PROD_W - FRAC_BITS + 1;

   typedef struct packed {
      logic signed [POS_W-1:0]  pos;
      logic signed [HEAD_W-1:0] head;
      logic signed [SIDE_W-1:0] side;
   } axis_type;

endpackage

// File: src/voxel_ray_cell_step.sv
// ----------------------------------------------------------------------------
// voxel_ray_cell_step
// One step of a voxel-grid ray walk: move a Q16.16 point to the nearest
// unit-cell side along its heading.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the result word is taken; the 33-stage divider sets the depth.
// The whole pipe stalls as one when the result word is not taken.
// Reset (synchronous, active high) clears the stage valid bits only.
module voxel_ray_cell_step import vrcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x[31:0] start_y[63:32] start_z[95:64]
   // heading_x[113:96] heading_y[131:114] heading_z[149:132], zero pad
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // next_x[31:0] next_y[63:32] next_z[95:64] travel[128:96]
   // hit_axes[131:129], zero pad
   output logic [135:0] rsp_tdata,
   // no_heading[0]
   output logic [0:0]   rsp_tuser
);

   localparam int LAT = QUO_W + 4;

   logic           en;
   logic [LAT-1:0] vld_ff;

   assign en         = ~vld_ff[LAT-1] | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // ---- prep: cell side, numerator and divisor per axis
   axis_type [2:0]    prep_in;
   logic [QUO_W-1:0]  num_in [3];
   logic [HEAD_W-1:0] den_in [3];
   axis_type [2:0]    prep_ff;
   logic [QUO_W-1:0]  num_ff [3];
   logic [HEAD_W-1:0] den_ff [3];

   always_comb begin
      logic signed [POS_W-1:0]  p;
      logic signed [HEAD_W-1:0] d;
      logic [FRAC_BITS-1:0]     frac;
      logic                     frac_zero;
      logic signed [SIDE_W-1:0] p_ext;
      logic signed [SIDE_W-1:0] p_floor;
      logic [FRAC_BITS:0]       an;
      for (int i = 0; i < 3; i++) begin
         p         = req_tdata[i*POS_W +: POS_W];
         d         = req_tdata[3*POS_W + i*HEAD_W +: HEAD_W];
         frac      = p[FRAC_BITS-1:0];
         frac_zero = (frac == '0);
         p_ext     = SIDE_W'(p);
         p_floor   = {p_ext[SIDE_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
         if (!d[HEAD_W-1]) begin
            prep_in[i].side = p_floor + (SIDE_W'(1) <<< FRAC_BITS);
            an = (FRAC_BITS+1)'(1) << FRAC_BITS;
            an = an - {1'b0, frac};
         end else begin
            prep_in[i].side = frac_zero ? p_ext - (SIDE_W'(1) <<< FRAC_BITS) : p_floor;
            an = frac_zero ? (FRAC_BITS+1)'(1) << FRAC_BITS : {1'b0, frac};
         end
         prep_in[i].pos  = p;
         prep_in[i].head = d;
         num_in[i] = QUO_W'(an) << FRAC_BITS;
         den_in[i] = d[HEAD_W-1] ? HEAD_W'(-d) : HEAD_W'(d);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= prep_in;
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= num_in[i];
            den_ff[i] <= den_in[i];
         end
      end
   end

   // ---- dividers, with the axis data riding alongside
   logic [QUO_W-1:0] quo_span [3];
   axis_type [2:0]   band_ff [QUO_W];

   for (genvar i = 0; i < 3; i++) begin : g_div
      vrcs_div u_div (
         .clock  (clock),
         .enable (en),
         .num    (num_ff[i]),
         .den    (den_ff[i]),
         .quo    (quo_span[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         band_ff[0] <= prep_ff;
         for (int k = 1; k < QUO_W; k++) begin
            band_ff[k] <= band_ff[k-1];
         end
      end
   end

   // ---- minimum over moving axes
   axis_type [2:0]   m_ax_ff;
   logic [QUO_W-1:0] m_dist_ff [3];
   logic [QUO_W-1:0] m_best_ff;
   logic [2:0]       m_on_ff;
   logic [QUO_W-1:0] m_best_in;

   always_comb begin
      logic [QUO_W-1:0] best;
      logic             have;
      best = '0;
      have = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (band_ff[QUO_W-1][i].head != '0 && (!have || quo_span[i] < best)) begin
            best = quo_span[i];
            have = 1'b1;
         end
      end
      m_best_in = best;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ax_ff   <= band_ff[QUO_W-1];
         m_best_ff <= m_best_in;
         for (int i = 0; i < 3; i++) begin
            m_dist_ff[i] <= quo_span[i];
            m_on_ff[i]   <= (band_ff[QUO_W-1][i].head != '0);
         end
      end
   end

   // ---- hits and advance products
   axis_type [2:0]          x_ax_ff;
   logic signed [PROD_W-1:0] x_prod_ff [3];
   logic [2:0]              x_hit_ff;
   logic [QUO_W-1:0]        x_best_ff;
   logic                    x_none_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ax_ff   <= m_ax_ff;
         x_best_ff <= m_best_ff;
         x_none_ff <= ~|m_on_ff;
         for (int i = 0; i < 3; i++) begin
            x_hit_ff[i]  <= m_on_ff[i] && (m_dist_ff[i] == m_best_ff);
            x_prod_ff[i] <= PROD_W'(m_ax_ff[i].head * $signed({1'b0, m_best_ff}));
         end
      end
   end

   // ---- new coordinates, saturated
   logic [POS_W-1:0]    o_pos_ff [3];
   logic [TRAVEL_W-1:0] o_travel_ff;
   logic [2:0]          o_hit_ff;
   logic                o_none_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         o_travel_ff <= TRAVEL_W'(x_best_ff);
         o_hit_ff    <= x_hit_ff;
         o_none_ff   <= x_none_ff;
         for (int i = 0; i < 3; i++) begin
            o_pos_ff[i] <= sat_pos(x_hit_ff[i] ? SUM_W'(x_ax_ff[i].side)
                           : SUM_W'(x_ax_ff[i].pos) + SUM_W'(x_prod_ff[i] >>> FRAC_BITS));
         end
      end
   end

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'({1'b0, {(POS_W-1){1'b1}}});
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return hi[POS_W-1:0];
      end else if (v < lo) begin
         return lo[POS_W-1:0];
      end
      return v[POS_W-1:0];
   endfunction

   assign rsp_tdata = {4'b0000, o_hit_ff, o_travel_ff, o_pos_ff[2], o_pos_ff[1], o_pos_ff[0]};
   assign rsp_tuser = o_none_ff;

endmodule

// File: src/vrcs_div.sv
// ----------------------------------------------------------------------------
// vrcs_div
// Pipelined restoring divider, one quotient bit per stage, QUO_W stages.
// ----------------------------------------------------------------------------
module vrcs_div import vrcs_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [QUO_W-1:0]  num,
   input  logic [HEAD_W-1:0] den,
   output logic [QUO_W-1:0]  quo
);

   logic [HEAD_W-1:0] rem_ff [QUO_W];
   logic [HEAD_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0]  num_ff [QUO_W];
   logic [QUO_W-1:0]  quo_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic [HEAD_W-1:0] rem_src;
      logic [HEAD_W-1:0] den_src;
      logic [QUO_W-1:0]  num_src;
      logic [QUO_W-1:0]  quo_src;
      logic [HEAD_W:0]   trial;
      logic [HEAD_W+1:0] diff;

      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign den_src = den;
         assign num_src = num;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign num_src = num_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      assign trial = {rem_src, num_src[QUO_W-1-s]};
      assign diff  = {1'b0, trial} - {2'b00, den_src};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s] <= diff[HEAD_W+1] ? trial[HEAD_W-1:0] : diff[HEAD_W-1:0];
            den_ff[s] <= den_src;
            num_ff[s] <= num_src;
            quo_ff[s] <= {quo_src[QUO_W-2:0], ~diff[HEAD_W+1]};
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

// File: dv/tb_voxel_ray_cell_step.sv
// ----------------------------------------------------------------------------
// tb_voxel_ray_cell_step
// Drives ray steps through the cell step pipeline and checks every result
// word against a local predictor of the cell-side step arithmetic.
// ----------------------------------------------------------------------------
module tb_voxel_ray_cell_step import vrcs_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  LATENCY   = QUO_W + 4;
   localparam longint LIMIT  = 2000000;
   localparam longint TRAVEL_TOP = (64'd1 << 33) - 1;

   typedef struct {
      logic [31:0] nx, ny, nz;
      logic [32:0] travel;
      logic [2:0]  hits;
      logic        no_head;
   } step_word_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [135:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   step_word_type expected_steps[$];
   int         errors = 0;
   longint     cycles = 0;
   bit         hold_off = 0;
   bit         stall_en = 1;

   voxel_ray_cell_step DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_voxel_ray_cell_step failed");
         $finish;
      end
   end

   function automatic longint floor_fx(longint x);
      if (x >= 0) return x >>> FRAC_BITS;
      return -(((-x) + ((64'sd1 << FRAC_BITS) - 1)) >>> FRAC_BITS);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic step_word_type predict_step(logic signed [31:0] p_in[3],
                                                  logic signed [17:0] d_in[3]);
      step_word_type r;
      longint p[3], d[3], side[3], span[3], one, best, num, a, hi, lo, adv, np;
      bit have;
      one = 64'sd1 << FRAC_BITS;
      have = 0; best = 0;
      for (int i = 0; i < 3; i++) begin
         p[i] = p_in[i]; d[i] = d_in[i]; span[i] = 0; side[i] = 0;
      end
      r.hits = 0; r.no_head = 0;
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
         r.nx = p[0]; r.ny = p[1]; r.nz = p[2]; r.travel = 0; r.no_head = 1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         if (d[i] == 0) continue;
         side[i] = d[i] > 0 ? (floor_fx(p[i]) + 1) * one : (-floor_fx(-p[i]) - 1) * one;
         num = side[i] - p[i];
         if (num < 0) num = -num;
         span[i] = (num << FRAC_BITS) / (d[i] < 0 ? -d[i] : d[i]);
         if (!have || span[i] < best) begin
            best = span[i]; have = 1;
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (d[i] != 0 && span[i] == best) begin
            r.hits[i] = 1; np = side[i];
         end else begin
            a = d[i] < 0 ? -d[i] : d[i];
            hi = a * (best >>> FRAC_BITS);
            lo = a * (best & (one - 1));
            adv = d[i] >= 0 ? hi + (lo >>> FRAC_BITS) : -(hi + ((lo + one - 1) >>> FRAC_BITS));
            np = p[i] + adv;
         end
         np = clamp32(np);
         if (i == 0) r.nx = np; else if (i == 1) r.ny = np; else r.nz = np;
      end
      r.travel = best > TRAVEL_TOP ? TRAVEL_TOP[32:0] : best[32:0];
      return r;
   endfunction

   function automatic int gap_len();
      int c = $urandom_range(0, 99);
      if (c < 55) return 0;
      if (c < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_ray(logic signed [31:0] x, y, z, logic signed [17:0] hx, hy, hz);
      logic signed [31:0] p[3];
      logic signed [17:0] d[3];
      int g;
      p = '{x, y, z}; d = '{hx, hy, hz};
      g = stall_en ? gap_len() : 0;
      // valid stays up between back-to-back words
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {2'b00, hz, hy, hx, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_steps.insert(expected_steps.size(), predict_step(p, d));
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= hold_off ? 0 : (!stall_en || $urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      step_word_type e, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.nx = rsp_tdata[31:0]; got.ny = rsp_tdata[63:32]; got.nz = rsp_tdata[95:64];
         got.travel = rsp_tdata[128:96]; got.hits = rsp_tdata[131:129];
         got.no_head = rsp_tuser[0];
         if (expected_steps.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            e = expected_steps.pop_front();
            if (got.nx !== e.nx) begin
               $error("next_x exp %h got %h", e.nx, got.nx); errors++;
            end
            if (got.ny !== e.ny) begin
               $error("next_y exp %h got %h", e.ny, got.ny); errors++;
            end
            if (got.nz !== e.nz) begin
               $error("next_z exp %h got %h", e.nz, got.nz); errors++;
            end
            if (got.travel !== e.travel) begin
               $error("travel exp %h got %h", e.travel, got.travel); errors++;
            end
            if (got.hits !== e.hits) begin
               $error("hit_axes exp %h got %h", e.hits, got.hits); errors++;
            end
            if (got.no_head !== e.no_head) begin
               $error("no_heading exp %h got %h", e.no_head, got.no_head); errors++;
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_pos();
      int c = $urandom_range(0, 9);
      logic [31:0] v = $urandom;
      if (c == 0) return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 'h30000)
                                               : 32'h80000000 + $urandom_range(0, 'h30000);
      if (c == 1) return {v[31:16], 16'h0000};
      if (c < 6) return $signed({{12{v[19]}}, v[19:0]});
      return v;
   endfunction

   function automatic logic signed [17:0] rand_head();
      int c = $urandom_range(0, 9);
      if (c == 0) return 0;
      if (c == 1) return $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
      if (c == 2) return $signed(18'($urandom));
      if (c == 3) return $signed(18'($urandom_range(1, 8))) * ($urandom_range(0, 1) ? 1 : -1);
      return $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
   endfunction

   task automatic test_directed();
      send_ray(0, 0, 0, 0, 0, 0);
      send_ray(32'h12345678, -5, 32'h80000000, 0, 0, 0);
      send_ray(0, 0, 0, 65536, 65536, 65536);
      send_ray(32'h00018000, 32'h00010000, -32'h8000, -65536, 65536, 0);
      send_ray(32'h7fffffff, 32'h80000000, 0, 65536, -65536, 1);
      send_ray(32'h7fff8000, 32'h80008000, 1, 65536, -65536, -1);
      send_ray(32'h7fffffff, 32'h80000000, 32'h7fff0000, 1, -1, 65536);
      send_ray(5, 5, 5, 1, 0, 0);
      send_ray(-5, -5, -5, 0, -1, 0);
      send_ray(32'h00010000, -32'h10000, 0, 65535, -65535, 3);
      send_ray(0, 0, 0, 18'sh1ffff, -18'sh20000, 0);
      send_ray(32'hffffffff, 32'h00000001, 32'h0000ffff, -131072, 131071, 2);
      send_ray(32'h00004000, 32'h00008000, 32'h0000c000, 65536, 65536, -65536);
      send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 65536, 65536, 65536);
      send_ray(32'h80000000, 32'h80000000, 32'h80000000, -65536, -65536, -65536);
   endtask

   task automatic test_random(int n);
      repeat (n) send_ray(rand_pos(), rand_pos(), rand_pos(),
                          rand_head(), rand_head(), rand_head());
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1;
            repeat (200) @(posedge clock);
            hold_off = 0;
         end
         begin
            stall_en = 0;
            test_random(120);
            stall_en = 1;
         end
      join
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      test_directed();
      test_backpressure();
      test_random(900);
      stall_en = 0;
      test_random(300);
      stall_en = 1;
      test_random(600);
      req_tvalid <= 0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("tb_voxel_ray_cell_step passed");
      else
         $display("tb_voxel_ray_cell_step failed");
      $finish;
   end
endmodule
